// ----- src/cr3bp_acceleration_core_defines.svh -----
// Assertion macros shared by the acceleration core.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef CR3BP_ACCELERATION_CORE_DEFINES_SVH
`define CR3BP_ACCELERATION_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define CR3_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define CR3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cr3_pkg.sv -----
// Shared types and fixed-point constants of the acceleration core.
// No dependencies.
`timescale 1ns / 1ps
package cr3_pkg;
  localparam int unsigned MU_W        = 24;
  localparam int unsigned K_W         = 25;
  localparam logic [MU_W-1:0] MU_RESET = 24'd203855;
  localparam logic [K_W-1:0]  ONE_Q24  = 25'h1000000;

  localparam int unsigned NORM_TOP    = 29;   // normalised top bit position
  localparam int unsigned N_W         = 30;
  localparam int unsigned SQ_W        = 60;
  localparam int unsigned SUM_W       = 62;
  localparam int unsigned SQRT_W      = 64;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned R_W         = 31;
  localparam int unsigned Q_W         = 34;
  localparam int unsigned DIV_STEPS   = 34;
  localparam int unsigned DIV_COUNT   = 3;
  localparam int unsigned DIV_LAT     = DIV_STEPS * DIV_COUNT;
  localparam int unsigned PRE_LAT     = 4;
  localparam int unsigned MUL_W       = 59;
  localparam int unsigned SCALE_BIAS  = 15;   // 2*NORM_TOP - 43
  localparam int unsigned TERM_W      = 61;
  localparam logic [TERM_W-1:0] TERM_LIM = 61'(1) << 60;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned ACC_SUM_W   = 64;
  localparam int unsigned PULL_LAT    = PRE_LAT + SQRT_STEPS + DIV_LAT + 2;

  localparam int unsigned FAULT_W     = 2;
  localparam logic [FAULT_W-1:0] FAULT_OK   = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_SAT  = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_ZERO = 2'd2;

  typedef logic [TERM_W-1:0] term_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic lim;
  } pull_stat_t;
endpackage

// ----- src/cr3_if.sv -----
// Request channels of the acceleration core: state vector in, acceleration out.
// Depends on cr3_pkg.
`timescale 1ns / 1ps
interface cr3_in_if #(parameter int unsigned COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] vel_x;
  logic signed [COORD_WIDTH-1:0] vel_y;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, output ready);
endinterface

interface cr3_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cr3_pkg::ACC_W-1:0] acc_x;
  logic signed [cr3_pkg::ACC_W-1:0] acc_y;
  logic signed [cr3_pkg::ACC_W-1:0] acc_z;
  logic [cr3_pkg::FAULT_W-1:0]      fault;
  modport source (output valid, acc_x, acc_y, acc_z, fault, input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, fault, output ready);
endinterface

// ----- src/cr3_sqrt_step.sv -----
// One digit step of the pipelined integer square root.
// Depends on cr3_pkg.
`timescale 1ns / 1ps
module cr3_sqrt_step #(
  parameter int unsigned BIT_IDX = 62
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cr3_pkg::SQRT_W-1:0]  v_i,
  input  logic [cr3_pkg::SQRT_W-1:0]  res_i,
  output logic [cr3_pkg::SQRT_W-1:0]  v_o,
  output logic [cr3_pkg::SQRT_W-1:0]  res_o
);
  import cr3_pkg::*;

  localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << BIT_IDX;

  logic [SQRT_W-1:0] v_r, res_r, v_nxt, res_nxt, trial;

  always_comb begin
    trial = res_i + BIT;
    if (v_i >= trial) begin
      v_nxt   = v_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
    end
  end

  assign v_o   = v_r;
  assign res_o = res_r;
endmodule

// ----- src/cr3_div_step.sv -----
// One quotient bit of the pipelined restoring divider.
// Depends on cr3_pkg.
`timescale 1ns / 1ps
module cr3_div_step (
  input  logic                    clk,
  input  logic                    en,
  input  logic [cr3_pkg::R_W-1:0] rem_i,
  input  logic [cr3_pkg::Q_W-1:0] dq_i,
  input  logic [cr3_pkg::R_W-1:0] div_i,
  output logic [cr3_pkg::R_W-1:0] rem_o,
  output logic [cr3_pkg::Q_W-1:0] dq_o,
  output logic [cr3_pkg::R_W-1:0] div_o
);
  import cr3_pkg::*;

  logic [R_W:0]   shifted;
  logic           ge;
  logic [R_W-1:0] rem_r, rem_nxt, div_r;
  logic [Q_W-1:0] dq_r, dq_nxt;

  // shift in the next dividend bit, subtract where it fits
  always_comb begin
    shifted = {rem_i, dq_i[Q_W-1]};
    ge      = shifted >= {1'b0, div_i};
    rem_nxt = ge ? R_W'(shifted - {1'b0, div_i}) : shifted[R_W-1:0];
    dq_nxt  = {dq_i[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      div_r <= div_i;
    end
  end

  assign rem_o = rem_r;
  assign dq_o  = dq_r;
  assign div_o = div_r;
endmodule

// ----- src/cr3_pull.sv -----
// Gravity pull k*d/|d|^3 of one primary: normalise, sum of squares, square root,
// three chained divisions per component, weight and scale. Uses cr3_sqrt_step,
// cr3_div_step and cr3_pkg.
`timescale 1ns / 1ps
module cr3_pull #(
  parameter int unsigned MAG_W = 33
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][MAG_W-1:0]               in_mag,
  input  logic [cr3_pkg::K_W-1:0]             k,
  output cr3_pkg::pull_stat_t                 out_stat,
  output logic [2:0][cr3_pkg::TERM_W-1:0]     out_mag
);
  import cr3_pkg::*;

  localparam int unsigned PW   = $clog2(MAG_W);
  localparam int unsigned DLY  = SQRT_STEPS + DIV_LAT;
  localparam int unsigned WD_W = MAG_W + NORM_TOP;
  localparam int unsigned TL_W = MUL_W + SCALE_BIAS;

  // stage 1: largest component and its top bit
  logic [MAG_W-1:0]            mx;
  logic [PW-1:0]               pos;
  logic [2:0][MAG_W-1:0]       mag1_r;
  logic [PW-1:0]               p1_r;
  logic                        z1_r, v1_r;

  always_comb begin
    mx = in_mag[0];
    if (in_mag[1] > mx) mx = in_mag[1];
    if (in_mag[2] > mx) mx = in_mag[2];
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx[i]) pos = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= in_mag;
      p1_r   <= pos;
      z1_r   <= (mx == '0);
    end
  end

  // stage 2: normalise to top bit NORM_TOP
  logic [2:0][N_W-1:0] n_nxt, n2_r;
  logic [WD_W-1:0]     wide [3];
  logic [PW-1:0]       p2_r;
  logic                z2_r, v2_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wide[c]  = {mag1_r[c], {NORM_TOP{1'b0}}} >> p1_r;
      n_nxt[c] = wide[c][N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r <= n_nxt;
      p2_r <= p1_r;
      z2_r <= z1_r;
    end
  end

  // stage 3: squares
  logic [2:0][SQ_W-1:0] sq3_r;
  logic [2:0][N_W-1:0]  n3_r;
  logic [PW-1:0]        p3_r;
  logic                 z3_r, v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) sq3_r[c] <= n2_r[c] * n2_r[c];
      n3_r <= n2_r;
      p3_r <= p2_r;
      z3_r <= z2_r;
    end
  end

  // stage 4: sum of squares
  logic [SUM_W-1:0]     sum4_r;
  logic [2:0][N_W-1:0]  n4_r;
  logic [PW-1:0]        p4_r;
  logic                 z4_r, v4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum4_r <= SUM_W'(sq3_r[0]) + SUM_W'(sq3_r[1]) + SUM_W'(sq3_r[2]);
      n4_r   <= n3_r;
      p4_r   <= p3_r;
      z4_r   <= z3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // square root, one result bit a stage
  logic [SQRT_W-1:0] sv_w [SQRT_STEPS+1];
  logic [SQRT_W-1:0] sr_w [SQRT_STEPS+1];
  logic [R_W-1:0]    root;

  assign sv_w[0] = SQRT_W'(sum4_r);
  assign sr_w[0] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    cr3_sqrt_step #(.BIT_IDX(SQRT_W - 2 - 2 * j)) u_step (
      .clk   (clk),
      .en    (en),
      .v_i   (sv_w[j]),
      .res_i (sr_w[j]),
      .v_o   (sv_w[j+1]),
      .res_o (sr_w[j+1])
    );
  end

  assign root = sr_w[SQRT_STEPS][R_W-1:0];

  // hold normalised components alongside the root
  logic [2:0][N_W-1:0] nd_r [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      nd_r[0] <= n4_r;
      for (int i = 1; i < SQRT_STEPS; i++) nd_r[i] <= nd_r[i-1];
    end
  end

  // exponent, zero flag and valid through root and divisions
  logic [PW-1:0] pd_r [DLY];
  logic          zd_r [DLY];
  logic          vd_r [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= p4_r;
      zd_r[0] <= z4_r;
      for (int i = 1; i < DLY; i++) begin
        pd_r[i] <= pd_r[i-1];
        zd_r[i] <= zd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v4_r;
      for (int i = 1; i < DLY; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  // three chained divisions by the root per component
  logic [R_W-1:0] rin_w [3][DIV_LAT];
  logic [Q_W-1:0] qin_w [3][DIV_LAT];
  logic [R_W-1:0] din_w [3][DIV_LAT];
  logic [R_W-1:0] rout_w [3][DIV_LAT];
  logic [Q_W-1:0] qout_w [3][DIV_LAT];
  logic [R_W-1:0] dout_w [3][DIV_LAT];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    for (genvar s = 0; s < DIV_LAT; s++) begin : g_div
      if (s == 0) begin : g_first
        // (n << 33) / R
        assign rin_w[c][s] = R_W'(nd_r[SQRT_STEPS-1][c][N_W-1:1]);
        assign qin_w[c][s] = {nd_r[SQRT_STEPS-1][c][0], {(Q_W-1){1'b0}}};
        assign din_w[c][s] = root;
      end else if ((s % DIV_STEPS) == 0) begin : g_next
        // (t << 29) / R
        assign rin_w[c][s] = R_W'(qout_w[c][s-1][Q_W-1:Q_W-NORM_TOP]);
        assign qin_w[c][s] = {qout_w[c][s-1][Q_W-NORM_TOP-1:0], {NORM_TOP{1'b0}}};
        assign din_w[c][s] = dout_w[c][s-1];
      end else begin : g_pass
        assign rin_w[c][s] = rout_w[c][s-1];
        assign qin_w[c][s] = qout_w[c][s-1];
        assign din_w[c][s] = dout_w[c][s-1];
      end

      cr3_div_step u_step (
        .clk   (clk),
        .en    (en),
        .rem_i (rin_w[c][s]),
        .dq_i  (qin_w[c][s]),
        .div_i (din_w[c][s]),
        .rem_o (rout_w[c][s]),
        .dq_o  (qout_w[c][s]),
        .div_o (dout_w[c][s])
      );
    end
  end

  // weight by k at full product width
  logic [2:0][MUL_W-1:0] prod_r;
  logic [PW-1:0]         pm_r;
  logic                  zm_r, vm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= MUL_W'(qout_w[c][DIV_LAT-1]) * MUL_W'(k);
      end
      pm_r <= pd_r[DLY-1];
      zm_r <= zd_r[DLY-1];
    end
  end

  // scale by 2^(2e-43), limiting left shifts at the term limit
  logic [2:0][TERM_W-1:0] mag_nxt, om_r;
  logic [2:0]             lim_c;
  logic [TL_W-1:0]        tl;
  int unsigned            two_p, ls, rs;
  logic                   ol_r, oz_r, ov_r;

  always_comb begin
    two_p = 2 * int'(pm_r);
    tl    = '0;
    ls    = 0;
    rs    = 0;
    for (int c = 0; c < 3; c++) begin
      lim_c[c]   = 1'b0;
      mag_nxt[c] = '0;
      if (two_p <= SCALE_BIAS) begin
        ls = SCALE_BIAS - two_p;
        tl = TL_W'(prod_r[c]) << ls;
        if (tl > TL_W'(TERM_LIM)) begin
          lim_c[c]   = 1'b1;
          mag_nxt[c] = TERM_LIM;
        end else begin
          mag_nxt[c] = tl[TERM_W-1:0];
        end
      end else begin
        rs = two_p - SCALE_BIAS;
        if (rs < MUL_W) mag_nxt[c] = TERM_W'(prod_r[c] >> rs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      om_r <= mag_nxt;
      ol_r <= |lim_c;
      oz_r <= zm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      vm_r <= vd_r[DLY-1];
      ov_r <= vm_r;
    end
  end

  assign out_stat.valid = ov_r;
  assign out_stat.zero  = oz_r;
  assign out_stat.lim   = ol_r;
  assign out_mag        = om_r;
endmodule

// ----- src/cr3bp_acceleration_core.sv -----
// Throughput one per cycle while the output skid entry is free.
// The depth is set by the 32-step square root and the three 34-step dividers in series.
// A single pipeline enable stalls every stage while the output skid entry is full.
// Reset (rst_n, synchronous, active low) clears all valid bits and sets mu to 203855.
// Depends on cr3_pkg, cr3_if, cr3_pull and the core defines header.
`timescale 1ns / 1ps
`include "cr3bp_acceleration_core_defines.svh"
module cr3bp_acceleration_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  cr3_in_if.sink                   in_ch,
  cr3_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [cr3_pkg::MU_W-1:0] cfg_wdata
);
  import cr3_pkg::*;

  // magnitude of a coordinate plus a primary offset
  localparam int unsigned MW = COORD_WIDTH + 1;
  localparam int unsigned LW = (MW > TERM_W) ? MW : TERM_W;

  typedef struct packed {
    logic  xn, yn, zn, vxn, vyn, d1n, d2n, lim;
    term_t tx, ty, cx, cy;
  } side_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
    logic [FAULT_W-1:0]      fault;
  } res_t;

  // ---------------------------------------------------------------------------
  // Mass ratio register: to be written only while the pipeline is empty (the block
  // itself does not enforce this), so every stage may read it directly.
  // ---------------------------------------------------------------------------
  logic [MU_W-1:0] mass_ratio_r;
  logic [K_W-1:0]  k1, k2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_ratio_r <= MU_RESET;
    end else if (cfg_we) begin
      mass_ratio_r <= cfg_wdata;
    end
  end

  assign k1 = ONE_Q24 - K_W'(mass_ratio_r);
  assign k2 = K_W'(mass_ratio_r);

  // Pipeline advances whenever the skid entry is free.
  logic en, s_valid_r;
  assign en          = !s_valid_r;
  assign in_ch.ready = en;

  function automatic logic [MW-1:0] mag_of(input logic signed [COORD_WIDTH-1:0] r);
    logic [COORD_WIDTH-1:0] u;
    u = r[COORD_WIDTH-1] ? (~r + 1'b1) : r;
    return {1'b0, u};
  endfunction

  // ---------------------------------------------------------------------------
  // Stage T1: offsets to both primaries, position and Coriolis terms.
  // ---------------------------------------------------------------------------
  logic [MW-1:0]        xm, ym, zm, vxm, vym, mu_m, k1_m, d1m, d2m;
  logic                 xn, d1n, d2n, lim_tx, lim_ty, lim_cx, lim_cy;
  logic [LW-1:0]        xe, ye, vxe, vye;
  side_t                side_nxt, t1_side_r;
  logic [2:0][MW-1:0]   g1_in_r, g2_in_r;
  logic                 t1_v_r;

  always_comb begin
    xm   = mag_of(in_ch.pos_x);
    ym   = mag_of(in_ch.pos_y);
    zm   = mag_of(in_ch.pos_z);
    vxm  = mag_of(in_ch.vel_x);
    vym  = mag_of(in_ch.vel_y);
    xn   = in_ch.pos_x[COORD_WIDTH-1];
    mu_m = MW'(mass_ratio_r);
    k1_m = MW'(k1);

    // x + mu
    if (!xn) begin
      d1n = 1'b0;
      d1m = xm + mu_m;
    end else if (xm >= mu_m) begin
      d1n = 1'b1;
      d1m = xm - mu_m;
    end else begin
      d1n = 1'b0;
      d1m = mu_m - xm;
    end

    // x - (1 - mu)
    if (xn) begin
      d2n = 1'b1;
      d2m = xm + k1_m;
    end else if (xm >= k1_m) begin
      d2n = 1'b0;
      d2m = xm - k1_m;
    end else begin
      d2n = 1'b1;
      d2m = k1_m - xm;
    end

    // limit position terms, double velocity terms with the same limit
    xe     = LW'(xm);
    ye     = LW'(ym);
    vxe    = LW'(vxm);
    vye    = LW'(vym);
    lim_tx = xe > LW'(TERM_LIM);
    lim_ty = ye > LW'(TERM_LIM);
    lim_cx = vye > LW'(TERM_LIM >> 1);
    lim_cy = vxe > LW'(TERM_LIM >> 1);

    side_nxt.xn  = xn;
    side_nxt.yn  = in_ch.pos_y[COORD_WIDTH-1];
    side_nxt.zn  = in_ch.pos_z[COORD_WIDTH-1];
    side_nxt.vxn = in_ch.vel_x[COORD_WIDTH-1];
    side_nxt.vyn = in_ch.vel_y[COORD_WIDTH-1];
    side_nxt.d1n = d1n;
    side_nxt.d2n = d2n;
    side_nxt.lim = lim_tx | lim_ty | lim_cx | lim_cy;
    side_nxt.tx  = lim_tx ? TERM_LIM : TERM_W'(xe);
    side_nxt.ty  = lim_ty ? TERM_LIM : TERM_W'(ye);
    side_nxt.cx  = lim_cx ? TERM_LIM : TERM_W'(vye << 1);
    side_nxt.cy  = lim_cy ? TERM_LIM : TERM_W'(vxe << 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_side_r  <= side_nxt;
      g1_in_r    <= {zm, ym, d1m};
      g2_in_r    <= {zm, ym, d2m};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= in_ch.valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Gravity of both primaries; the two pulls run in lockstep.
  // ---------------------------------------------------------------------------
  pull_stat_t              st1, st2;
  logic [2:0][TERM_W-1:0]  g1, g2;

  cr3_pull #(.MAG_W(MW)) u_pull1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (t1_v_r),
    .in_mag   (g1_in_r),
    .k        (k1),
    .out_stat (st1),
    .out_mag  (g1)
  );

  cr3_pull #(.MAG_W(MW)) u_pull2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (t1_v_r),
    .in_mag   (g2_in_r),
    .k        (k2),
    .out_stat (st2),
    .out_mag  (g2)
  );

  // Hold signs and side terms level with the pulls.
  side_t sd_r [PULL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= t1_side_r;
      for (int i = 1; i < PULL_LAT; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage T2: exact sums per axis, four terms for x and y, two for z.
  // ---------------------------------------------------------------------------
  function automatic logic signed [ACC_SUM_W-1:0] ts(input term_t m, input logic neg);
    logic signed [ACC_SUM_W-1:0] v;
    v = signed'(ACC_SUM_W'(m));
    return neg ? -v : v;
  endfunction

  side_t                       sa;
  logic signed [ACC_SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic                        t2_zero_r, t2_lim_r, t2_v_r;

  assign sa = sd_r[PULL_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x_r   <= ts(sa.tx, sa.xn) + ts(g1[0], !sa.d1n) + ts(g2[0], !sa.d2n)
                   + ts(sa.cx, sa.vyn);
      sum_y_r   <= ts(sa.ty, sa.yn) + ts(g1[1], !sa.yn) + ts(g2[1], !sa.yn)
                   + ts(sa.cy, !sa.vxn);
      sum_z_r   <= ts(g1[2], !sa.zn) + ts(g2[2], !sa.zn);
      t2_zero_r <= st1.zero | st2.zero;
      t2_lim_r  <= sa.lim | st1.lim | st2.lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else if (en) begin
      t2_v_r <= st1.valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate to Q24.24 and apply the zero-distance case.
  // ---------------------------------------------------------------------------
  localparam logic signed [ACC_SUM_W-1:0] OUT_MAX = (ACC_SUM_W'(1) <<< (ACC_W - 1)) - 1;
  localparam logic signed [ACC_SUM_W-1:0] OUT_MIN = -(ACC_SUM_W'(1) <<< (ACC_W - 1));

  function automatic logic [ACC_W:0] sat(input logic signed [ACC_SUM_W-1:0] s);
    if (s > OUT_MAX) return {1'b1, OUT_MAX[ACC_W-1:0]};
    if (s < OUT_MIN) return {1'b1, OUT_MIN[ACC_W-1:0]};
    return {1'b0, s[ACC_W-1:0]};
  endfunction

  logic [ACC_W:0] sx, sy, sz;
  res_t           res_nxt;

  always_comb begin
    sx = sat(sum_x_r);
    sy = sat(sum_y_r);
    sz = sat(sum_z_r);
    if (t2_zero_r) begin
      res_nxt.acc_x = '0;
      res_nxt.acc_y = '0;
      res_nxt.acc_z = '0;
      res_nxt.fault = FAULT_ZERO;
    end else begin
      res_nxt.acc_x = sx[ACC_W-1:0];
      res_nxt.acc_y = sy[ACC_W-1:0];
      res_nxt.acc_z = sz[ACC_W-1:0];
      res_nxt.fault = (t2_lim_r | sx[ACC_W] | sy[ACC_W] | sz[ACC_W]) ? FAULT_SAT : FAULT_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid entry: the stall enable is taken from the registered skid
  // flag, so the result that the pipeline still delivers as the sink stalls parks in the skid.
  // ---------------------------------------------------------------------------
  res_t o_r, s_r;
  logic o_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else if (s_valid_r) begin
      if (out_ch.ready) begin
        s_valid_r <= 1'b0;
      end
    end else if (!o_valid_r || out_ch.ready) begin
      o_valid_r <= t2_v_r;
    end else if (t2_v_r) begin
      s_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid_r) begin
      if (out_ch.ready) begin
        o_r <= s_r;
      end
    end else if (!o_valid_r || out_ch.ready) begin
      o_r <= res_nxt;
    end else begin
      s_r <= res_nxt;
    end
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.acc_x = o_r.acc_x;
  assign out_ch.acc_y = o_r.acc_y;
  assign out_ch.acc_z = o_r.acc_z;
  assign out_ch.fault = o_r.fault;

  `CR3_ASSERT_IMPL(a_skid_has_head, s_valid_r, o_valid_r, "skid entry held without output entry")
  `CR3_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, t1_v_r, "accepted request lost")
  `CR3_ASSERT_IMPL(a_pulls_aligned, 1'b1, st1.valid == st2.valid, "gravity pipelines out of step")
  `CR3_ASSERT_IMPL(a_zero_clears, o_valid_r && (o_r.fault == FAULT_ZERO), (o_r.acc_x == '0) && (o_r.acc_y == '0) && (o_r.acc_z == '0), "zero distance with nonzero output")
endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the CR3BP acceleration core: directed rows, then random requests.
// Predicts each result in fixed point, unless a row gives it by hand, and compares it field by field.
// Depends on cr3_pkg, cr3_if and the core itself.
`timescale 1ns / 1ps
module tb;
  import cr3_pkg::*;

  localparam int CW        = 32;
  localparam int IDLE_WAIT = 200;   // comfortably above the pipeline latency
  localparam int WDOG_LIM  = 5000;  // cycles with no handshake on either channel
  localparam int RAND_PER  = 100;   // random requests per mass-ratio setting

  typedef struct {
    logic signed [CW-1:0] px, py, pz, vx, vy;
  } state_vec_t;

  typedef struct {
    logic [ACC_W-1:0]   ax, ay, az;
    logic [FAULT_W-1:0] fault;
  } accel_t;

  typedef struct {
    state_vec_t sv;
    bit         typed;   // expectation written by hand below
    accel_t     acc;
  } row_t;

  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } smag_t;

  typedef smag_t vec3_t [3];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [MU_W-1:0] cfg_wdata = '0;

  cr3_in_if #(.COORD_WIDTH(CW)) in_ch ();
  cr3_out_if                    out_ch ();

  cr3bp_acceleration_core #(.COORD_WIDTH(CW)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Bench copy of the mass ratio, and the accelerations still owed by the core.
  logic [MU_W-1:0] mu_q24 = MU_RESET;
  accel_t          accel_due[$];
  bit              cur_typed;
  accel_t          cur_acc;
  int              errors = 0;
  int              sent = 0;
  int              got = 0;
  int              faults_seen [3] = '{0, 0, 0};
  int              settings = 1;
  int              idle_cycles = 0;
  int unsigned     cyc = 0;

  // ---------------------------------------------------------------------------
  // Predictor: sign-magnitude arithmetic in units of 2^-24, 64-bit wrap-around.
  // ---------------------------------------------------------------------------
  function automatic smag_t to_smag(input logic [CW-1:0] raw);
    smag_t r;
    logic [CW-1:0] u;
    r.neg = raw[CW-1];
    u = ~raw + 1'b1;
    r.mag = r.neg ? 64'(u) : 64'(raw);
    return r;
  endfunction

  function automatic smag_t add_smag(input smag_t a, input smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg; r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg; r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg; r.mag = b.mag - a.mag;
    end
    return r;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Pull k*d/|d|^3 per axis; returns 0 when the offset is zero.
  function automatic bit gravity_pull(input vec3_t d, input logic [63:0] k,
                                      output vec3_t g, inout bit lim);
    logic [63:0] m, v, sum, r, t;
    logic [63:0] n [3];
    int p, e, sh;
    m = 0;
    sum = 0;
    p = 0;
    g = d;
    for (int i = 0; i < 3; i++) if (d[i].mag > m) m = d[i].mag;
    if (m == 0) return 1'b0;
    v = m;
    while (v > 1) begin
      v = v >> 1;
      p++;
    end
    e = 29 - p;
    for (int i = 0; i < 3; i++) begin
      n[i] = (e >= 0) ? (d[i].mag << e) : (d[i].mag >> (-e));
      sum = sum + n[i] * n[i];
    end
    r = int_sqrt(sum);
    sh = 2 * e - 43;
    for (int i = 0; i < 3; i++) begin
      t = (n[i] << 33) / r;
      t = (t << 29) / r;
      t = (t << 29) / r;
      t = t * k;
      if (sh >= 0) begin
        if (t > ((64'd1 << 60) >> sh)) begin
          t = 64'd1 << 60;
          lim = 1'b1;
        end else begin
          t = t << sh;
        end
      end else begin
        t = (-sh >= 64) ? 64'd0 : (t >> (-sh));
      end
      g[i].neg = d[i].neg;
      g[i].mag = t;
    end
    return 1'b1;
  endfunction

  function automatic longint signed_of(input smag_t a);
    return a.neg ? -longint'(a.mag) : longint'(a.mag);
  endfunction

  function automatic logic [ACC_W-1:0] clamp_acc(input longint s, inout bit lim);
    if (s > (64'sd1 <<< 47) - 1) begin
      s = (64'sd1 <<< 47) - 1; lim = 1'b1;
    end else if (s < -(64'sd1 <<< 47)) begin
      s = -(64'sd1 <<< 47); lim = 1'b1;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic accel_t predict_accel(input state_vec_t s, input logic [MU_W-1:0] mu);
    accel_t a;
    smag_t x, y, z, vx, vy, off1, off2, tx, ty, cx, cy;
    vec3_t d1, d2, g1, g2;
    logic [63:0] k1, k2;
    bit lim, ok1, ok2;
    lim = 1'b0;
    x = to_smag(s.px); y = to_smag(s.py); z = to_smag(s.pz);
    vx = to_smag(s.vx); vy = to_smag(s.vy);
    k1 = (64'd1 << 24) - 64'(mu);
    k2 = 64'(mu);
    off1.neg = 1'b0; off1.mag = k2;
    off2.neg = 1'b1; off2.mag = k1;
    d1[0] = add_smag(x, off1);
    d2[0] = add_smag(x, off2);
    d1[1] = y; d2[1] = y;
    d1[2] = z; d2[2] = z;
    ok1 = gravity_pull(d1, k1, g1, lim);
    ok2 = gravity_pull(d2, k2, g2, lim);
    if (!ok1 || !ok2) begin
      a.ax = '0; a.ay = '0; a.az = '0; a.fault = FAULT_ZERO;
      return a;
    end
    for (int i = 0; i < 3; i++) begin
      g1[i].neg = !g1[i].neg;
      g2[i].neg = !g2[i].neg;
    end
    tx = x; ty = y; cx = vy; cy = vx;
    // Position terms are limited to 2^60, the Coriolis terms doubled with the same limit.
    if (tx.mag > (64'd1 << 60)) begin tx.mag = 64'd1 << 60; lim = 1'b1; end
    if (ty.mag > (64'd1 << 60)) begin ty.mag = 64'd1 << 60; lim = 1'b1; end
    if (cx.mag > (64'd1 << 59)) begin cx.mag = 64'd1 << 60; lim = 1'b1; end
    else cx.mag = cx.mag * 2;
    if (cy.mag > (64'd1 << 59)) begin cy.mag = 64'd1 << 60; lim = 1'b1; end
    else cy.mag = cy.mag * 2;
    cy.neg = !cy.neg;
    a.ax = clamp_acc(signed_of(tx) + signed_of(g1[0]) + signed_of(g2[0]) + signed_of(cx), lim);
    a.ay = clamp_acc(signed_of(ty) + signed_of(g1[1]) + signed_of(g2[1]) + signed_of(cy), lim);
    a.az = clamp_acc(signed_of(g1[2]) + signed_of(g2[2]), lim);
    a.fault = lim ? FAULT_SAT : FAULT_OK;
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Request-side monitor: record an expectation for every accepted state vector.
  // Result-side monitor: compare each accepted acceleration with the oldest one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    state_vec_t s;
    accel_t e;
    cyc <= cyc + 1;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s.px = in_ch.pos_x; s.py = in_ch.pos_y; s.pz = in_ch.pos_z;
      s.vx = in_ch.vel_x; s.vy = in_ch.vel_y;
      accel_due.push_back(cur_typed ? cur_acc : predict_accel(s, mu_q24));
      sent++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got++;
      if (accel_due.size() == 0) begin
        $display("%0t: unexpected result acc=(%h %h %h) fault=%0d", $time,
                 out_ch.acc_x, out_ch.acc_y, out_ch.acc_z, out_ch.fault);
        errors++;
      end else begin
        e = accel_due.pop_front();
        if (out_ch.fault <= 2) faults_seen[out_ch.fault]++;
        if (out_ch.acc_x !== e.ax) begin
          $display("%0t: acc_x expected %h got %h", $time, e.ax, out_ch.acc_x); errors++;
        end
        if (out_ch.acc_y !== e.ay) begin
          $display("%0t: acc_y expected %h got %h", $time, e.ay, out_ch.acc_y); errors++;
        end
        if (out_ch.acc_z !== e.az) begin
          $display("%0t: acc_z expected %h got %h", $time, e.az, out_ch.acc_z); errors++;
        end
        if (out_ch.fault !== e.fault) begin
          $display("%0t: fault expected %0d got %0d", $time, e.fault, out_ch.fault); errors++;
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIM) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, accel_due.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result receiver: cycle through free-running, light-stall and heavy-stall stretches.
  always @(negedge clk) begin
    case ((cyc >> 7) % 3)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(input state_vec_t s, input bit typed, input accel_t acc);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= s.px; in_ch.pos_y <= s.py; in_ch.pos_z <= s.pz;
    in_ch.vel_x <= s.vx; in_ch.vel_y <= s.vy;
    cur_typed = typed;
    cur_acc = acc;
    do @(posedge clk); while (!in_ch.ready);
    // Bursts end in a random gap; hold valid low across it.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 12);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      cur_typed = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  endtask

  // Hold off until every owed result is back and the pipeline is empty.
  task automatic drain;
    while (accel_due.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // Drop valid before draining so the last request is not taken again.
  task automatic write_mu(input logic [MU_W-1:0] mu);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mu;
    @(posedge clk);
    mu_q24 = mu;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic signed [CW-1:0] jitter(input int span);
    return $signed(CW'($urandom_range(0, 2 * span))) - CW'(span);
  endfunction

  // Well-formed points around the primaries and in the usual orbit region, with
  // occasional full-range noise.
  function automatic state_vec_t random_state(input logic [MU_W-1:0] mu);
    state_vec_t s;
    int sel;
    logic signed [CW-1:0] base;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      s.px = jitter(1 << 26); s.py = jitter(1 << 26); s.pz = jitter(1 << 24);
      s.vx = jitter(1 << 25); s.vy = jitter(1 << 25);
    end else if (sel < 7) begin
      base = $urandom_range(0, 1) ? -$signed(CW'(mu)) : $signed(CW'(25'h1000000 - mu));
      if ($urandom_range(0, 7) == 0) begin
        s.px = base; s.py = 0; s.pz = 0;   // exactly on a primary
      end else begin
        s.px = base + jitter(256); s.py = jitter(256); s.pz = jitter(256);
      end
      s.vx = jitter(1 << 24); s.vy = jitter(1 << 24);
    end else begin
      s.px = $urandom; s.py = $urandom; s.pz = $urandom;
      s.vx = $urandom; s.vy = $urandom;
    end
    return s;
  endfunction

  row_t rows [$];
  logic [MU_W-1:0] mu_plan [5];
  accel_t zero_hit;
  accel_t none;

  initial begin
    state_vec_t s;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.vel_x = '0; in_ch.vel_y = '0;
    out_ch.ready = 1'b0;
    cur_typed = 1'b0;
    none = '{default: '0};
    zero_hit = '{ax: '0, ay: '0, az: '0, fault: FAULT_ZERO};
    mu_plan = '{24'd0, 24'd8388608, 24'hFFFFFF, 24'(MU_RESET), 24'd0};
    mu_plan[4] = 24'($urandom_range(0, 8388608));

    // Directed rows at the reset mass ratio; the two primaries sit at -mu and 1-mu.
    rows = '{
      '{'{0, 0, 0, 0, 0}, 0, none},
      '{'{-203855, 0, 0, 0, 0}, 1, zero_hit},                  // on the large primary
      '{'{16573361, 0, 0, 0, 0}, 1, zero_hit},                 // on the small primary
      '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 0, none},
      '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 0, none},
      '{'{-203854, 0, 0, 0, 0}, 0, none},                      // a hair off: limited pull
      '{'{16573362, 0, 1, 0, 0}, 0, none},
      '{'{-203855, 1, 0, 0, 0}, 0, none},
      '{'{-203855, 32'h80000000, 0, 0, 0}, 0, none},
      '{'{32'h01000000, 0, 0, 0, 32'h7FFFFFFF}, 0, none},
      '{'{32'h01000000, 0, 0, 32'h80000000, 0}, 0, none},
      '{'{32'h00800000, 0, 32'h7FFFFFFF, 0, 0}, 0, none},
      '{'{32'h80000000, 0, 0, 0, 0}, 0, none},
      '{'{32'h01000000, 32'h01000000, 32'h01000000, 32'h00800000, -32'sh00800000}, 0, none},
      '{'{32'h0D000000, -32'sh0DDDDDDD, 32'h00123456, 32'h7FFFFFFF, 32'h80000000}, 0, none}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table at the reset value of mu.
    foreach (rows[i]) send_request(rows[i].sv, rows[i].typed, rows[i].acc);

    // Random requests at the reset value, then at each further setting.
    for (int ph = 0; ph <= 5; ph++) begin
      if (ph > 0) write_mu(mu_plan[ph-1]);
      // With mu at zero the large primary sits at the origin and the small one at 1: aim at both.
      if (ph == 1) begin
        s = '{0, 0, 0, 0, 0};
        send_request(s, 1'b1, zero_hit);
        s = '{32'h01000000, 0, 0, 0, 0};
        send_request(s, 1'b1, zero_hit);
      end
      for (int n = 0; n < RAND_PER; n++) send_request(random_state(mu_q24), 1'b0, none);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    drain();

    $display("Sent %0d state vectors over %0d mass-ratio settings; %0d results checked",
             sent, settings, got);
    $display("Faults seen: %0d clean, %0d limited, %0d zero distance",
             faults_seen[0], faults_seen[1], faults_seen[2]);
    if (errors == 0 && accel_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
